// File: design/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the curve tessellator
// Register indexes, curve kind codes, fixed point widths, controller state
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pct_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG  = 2'd1;

  // curve kind: high bit selects Catmull-Rom, low bit cubic
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_QUAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CUBIC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CATMULL = 2'd2;
  localparam int KIND_BIT_CR    = 1;
  localparam int KIND_BIT_CUBIC = 0;

  localparam int SEG_W = 6;
  localparam logic [SEG_W-1:0] SEG_RESET = 6'd16;

  // parameter t, unsigned Q1.16
  localparam int T_W    = 17;
  localparam int FRAC_W = 16;

  // step divider: 2^17 / (2n)
  localparam int DIV_W     = SEG_W + 1;
  localparam int DIV_STEPS = T_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN,
    ST_DRAIN
  } pct_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic issue;
    logic last;
  } pct_cmd_t;

  typedef struct packed {
    logic             step_ok;
    logic             adv;
    logic             pipe_empty;
    logic [SEG_W-1:0] n_eff;
  } pct_status_t;

endpackage

// File: design/pct_divider.sv
// ----------------------------------------------------------------------------
// pct_divider: serial restoring divider for the t step
// Divides 2^17 by the even divisor 2n, one quotient bit per cycle, and
// holds quotient and remainder until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pct_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pct_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [pct_pkg::T_W-1:0]   quo,
  output logic [pct_pkg::DIV_W-1:0] rem
);
  import pct_pkg::*;

  localparam logic [DIV_STEPS-1:0] DIVIDEND = {1'b1, {T_W{1'b0}}};
  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_STEPS-1:0] dq_r, dq_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W:0]       rem_sh;
  logic                 fits;

  always_comb begin
    rem_sh   = {rem_r, dq_r[DIV_STEPS-1]};
    fits     = rem_sh >= {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = DIVIDEND;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DIV_STEPS-2:0], fits};
      rem_nxt = fits ? DIV_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = dq_r[T_W-1:0];
  assign rem  = rem_r;

endmodule

// File: design/pct_datapath.sv
// ----------------------------------------------------------------------------
// pct_datapath: configuration, coefficients, t stepper and point pipeline
// Power-form coefficients are set up once per item; each issued point runs
// t, t^2, t^3, products, sum and round/saturate stages to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pct_datapath #(
  parameter int COORD_WIDTH = pct_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [COORD_WIDTH-1:0]  ctrl0_x,
  input  logic signed [COORD_WIDTH-1:0]  ctrl0_y,
  input  logic signed [COORD_WIDTH-1:0]  ctrl1_x,
  input  logic signed [COORD_WIDTH-1:0]  ctrl1_y,
  input  logic signed [COORD_WIDTH-1:0]  ctrl2_x,
  input  logic signed [COORD_WIDTH-1:0]  ctrl2_y,
  input  logic signed [COORD_WIDTH-1:0]  ctrl3_x,
  input  logic signed [COORD_WIDTH-1:0]  ctrl3_y,
  input  pct_pkg::pct_cmd_t              cmd,
  output pct_pkg::pct_status_t           status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [COORD_WIDTH-1:0]  point_x,
  output logic signed [COORD_WIDTH-1:0]  point_y,
  output logic                           last_point
);
  import pct_pkg::*;

  localparam int CW   = COORD_WIDTH + 5;
  localparam int PW   = CW + T_W + 1;
  localparam int SW   = PW + 2;
  localparam int NSTG = 5;

  localparam logic [2*T_W-1:0]   RND_T  = (2*T_W)'(1) << (FRAC_W - 1);
  localparam logic signed [SW-1:0] RND_BZ = SW'(1) << (FRAC_W - 1);
  localparam logic signed [SW-1:0] RND_CR = SW'(1) << FRAC_W;
  localparam logic signed [SW-1:0] OUT_MAX =
    {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] OUT_MIN =
    {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  // configuration
  logic [KIND_W-1:0] kind_r;
  logic [SEG_W-1:0]  seg_r;
  logic              step_ok_r;
  logic [SEG_W-1:0]  n_eff;
  logic [DIV_W-1:0]  dvs;
  logic              div_done;
  logic [T_W-1:0]    step_q;
  logic [DIV_W-1:0]  step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_QUAD;
      seg_r  <= SEG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_KIND) begin
        kind_r <= cfg_data[KIND_W-1:0];
      end else if (cfg_index == CFG_IDX_SEG) begin
        seg_r <= cfg_data[SEG_W-1:0];
      end
    end
  end

  // step quotient stays good until segment_count is rewritten
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ok_r <= 1'b0;
    end else if (cfg_we && cfg_index == CFG_IDX_SEG) begin
      step_ok_r <= 1'b0;
    end else if (div_done) begin
      step_ok_r <= 1'b1;
    end
  end

  assign n_eff = (seg_r == '0) ? SEG_W'(1) : seg_r;
  assign dvs   = {n_eff, 1'b0};

  pct_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (dvs),
    .done    (div_done),
    .quo     (step_q),
    .rem     (step_r)
  );

  // coefficients
  logic signed [COORD_WIDTH-1:0] pin      [2][4];
  logic signed [CW-1:0]          e        [2][4];
  logic signed [CW-1:0]          d10      [2];
  logic signed [CW-1:0]          s2nd     [2];
  logic signed [CW-1:0]          t3c      [2];
  logic signed [CW-1:0]          coef_nxt [2][4];
  logic signed [CW-1:0]          coef_r   [2][4];
  logic                          cr_r;

  assign pin[0][0] = ctrl0_x;
  assign pin[1][0] = ctrl0_y;
  assign pin[0][1] = ctrl1_x;
  assign pin[1][1] = ctrl1_y;
  assign pin[0][2] = ctrl2_x;
  assign pin[1][2] = ctrl2_y;
  assign pin[0][3] = ctrl3_x;
  assign pin[1][3] = ctrl3_y;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 4; k++) begin
        e[a][k] = CW'(pin[a][k]);
      end
      d10[a]  = e[a][1] - e[a][0];
      s2nd[a] = e[a][0] - (e[a][1] <<< 1) + e[a][2];
      t3c[a]  = (e[a][1] - e[a][2]) + ((e[a][1] - e[a][2]) <<< 1) + e[a][3] - e[a][0];
      priority if (kind_r[KIND_BIT_CR]) begin
        coef_nxt[a][0] = e[a][1] <<< 1;
        coef_nxt[a][1] = e[a][2] - e[a][0];
        coef_nxt[a][2] = (e[a][0] <<< 1) - (e[a][1] <<< 2) - e[a][1]
                       + (e[a][2] <<< 2) - e[a][3];
        coef_nxt[a][3] = t3c[a];
      end else if (kind_r[KIND_BIT_CUBIC]) begin
        coef_nxt[a][0] = e[a][0];
        coef_nxt[a][1] = d10[a] + (d10[a] <<< 1);
        coef_nxt[a][2] = s2nd[a] + (s2nd[a] <<< 1);
        coef_nxt[a][3] = t3c[a];
      end else begin
        coef_nxt[a][0] = e[a][0];
        coef_nxt[a][1] = d10[a] <<< 1;
        coef_nxt[a][2] = s2nd[a];
        coef_nxt[a][3] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coef_r <= coef_nxt;
      cr_r   <= kind_r[KIND_BIT_CR];
    end
  end

  // t stepper: i*2^17 + n = 2n*t + r
  logic [T_W-1:0]   t_r;
  logic [DIV_W-1:0] r_r;
  logic [DIV_W:0]   r_sum;
  logic             wrap;

  assign r_sum = {1'b0, r_r} + {1'b0, step_r};
  assign wrap  = r_sum >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= '0;
      r_r <= DIV_W'(n_eff);
    end else if (cmd.issue) begin
      t_r <= t_r + step_q + T_W'(wrap);
      r_r <= wrap ? DIV_W'(r_sum - {1'b0, dvs}) : r_sum[DIV_W-1:0];
    end
  end

  // point pipeline
  logic                 adv;
  logic                 out_valid_r;
  logic [NSTG-1:0]      vld_r;
  logic [NSTG-1:0]      lst_r;
  logic [T_W-1:0]       t1_r;
  logic [T_W-1:0]       t_2_r, t2_2_r;
  logic [T_W-1:0]       t_3_r, t2_3_r, t3_3_r;
  logic [2*T_W-1:0]     sq, cu;
  logic signed [T_W:0]  ts, t2s, t3s;
  logic signed [PW-1:0] prod_nxt [2][3];
  logic signed [PW-1:0] prod_r   [2][3];
  logic signed [SW-1:0] sum_nxt  [2];
  logic signed [SW-1:0] sum_r    [2];
  logic signed [SW-1:0] rb       [2];
  logic signed [SW-1:0] rc       [2];
  logic signed [SW-1:0] rs       [2];
  logic signed [COORD_WIDTH-1:0] pt [2];
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic                 last_r;

  assign adv = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], cmd.issue};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  assign sq  = t1_r * t1_r + RND_T;
  assign cu  = t2_2_r * t_2_r + RND_T;
  assign ts  = signed'({1'b0, t_3_r});
  assign t2s = signed'({1'b0, t2_3_r});
  assign t3s = signed'({1'b0, t3_3_r});

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      prod_nxt[a][0] = coef_r[a][1] * ts;
      prod_nxt[a][1] = coef_r[a][2] * t2s;
      prod_nxt[a][2] = coef_r[a][3] * t3s;
      sum_nxt[a] = (SW'(coef_r[a][0]) <<< FRAC_W) + SW'(prod_r[a][0])
                 + SW'(prod_r[a][1]) + SW'(prod_r[a][2]);
      rb[a] = (sum_r[a] + RND_BZ) >>> FRAC_W;
      rc[a] = (sum_r[a] + RND_CR) >>> (FRAC_W + 1);
      rs[a] = cr_r ? rc[a] : rb[a];
      priority if (rs[a] > OUT_MAX) begin
        pt[a] = OUT_MAX[COORD_WIDTH-1:0];
      end else if (rs[a] < OUT_MIN) begin
        pt[a] = OUT_MIN[COORD_WIDTH-1:0];
      end else begin
        pt[a] = rs[a][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lst_r  <= {lst_r[NSTG-2:0], cmd.last};
      t1_r   <= t_r;
      t_2_r  <= t1_r;
      t2_2_r <= sq[FRAC_W +: T_W];
      t_3_r  <= t_2_r;
      t2_3_r <= t2_2_r;
      t3_3_r <= cu[FRAC_W +: T_W];
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
      px_r   <= pt[0];
      py_r   <= pt[1];
      last_r <= lst_r[NSTG-1];
    end
  end

  assign out_valid  = out_valid_r;
  assign point_x    = px_r;
  assign point_y    = py_r;
  assign last_point = last_r;

  assign status.step_ok    = step_ok_r;
  assign status.adv        = adv;
  assign status.pipe_empty = !(|vld_r) && !out_valid_r;
  assign status.n_eff      = n_eff;

endmodule

// File: design/pct_ctrl.sv
// ----------------------------------------------------------------------------
// pct_ctrl: item sequencer of the curve tessellator
// Takes an item, starts the step divider when needed, issues one point per
// free pipeline slot and waits for the pipeline to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pct_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output pct_pkg::pct_cmd_t    cmd,
  input  pct_pkg::pct_status_t status
);
  import pct_pkg::*;

  pct_state_t       state_r, state_nxt;
  logic [SEG_W-1:0] i_r, i_nxt;
  logic             is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
    end
  end

  assign is_last = (i_r == status.n_eff);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          i_nxt    = '0;
          if (status.step_ok) begin
            state_nxt = ST_RUN;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (status.step_ok) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.adv) begin
          cmd.issue = 1'b1;
          cmd.last  = is_last;
          if (is_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

endmodule

// File: design/parametric_curve_tessellator.sv
// ----------------------------------------------------------------------------
// parametric_curve_tessellator: Bezier / Catmull-Rom curve point generator
// Each item first waits for the serial t-step divider when segment_count was
// written since its last division or since reset, then issues its points.
// Throughput: one point per cycle while out_ready is high, n+1 points per item;
// the six-stage point pipeline drains before the next item is taken.
// Reset: synchronous, active low; curve_kind 0, segment_count 16, idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parametric_curve_tessellator #(
  parameter int COORD_WIDTH = pct_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_WIDTH-1:0]  in_ctrl0_x,
  input  logic signed [COORD_WIDTH-1:0]  in_ctrl0_y,
  input  logic signed [COORD_WIDTH-1:0]  in_ctrl1_x,
  input  logic signed [COORD_WIDTH-1:0]  in_ctrl1_y,
  input  logic signed [COORD_WIDTH-1:0]  in_ctrl2_x,
  input  logic signed [COORD_WIDTH-1:0]  in_ctrl2_y,
  input  logic signed [COORD_WIDTH-1:0]  in_ctrl3_x,
  input  logic signed [COORD_WIDTH-1:0]  in_ctrl3_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [COORD_WIDTH-1:0]  out_point_x,
  output logic signed [COORD_WIDTH-1:0]  out_point_y,
  output logic                           out_last_point
);
  import pct_pkg::*;

  pct_cmd_t    cmd;
  pct_status_t status;

  assign cfg_ready = 1'b1;

  pct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  pct_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctrl0_x    (in_ctrl0_x),
    .ctrl0_y    (in_ctrl0_y),
    .ctrl1_x    (in_ctrl1_x),
    .ctrl1_y    (in_ctrl1_y),
    .ctrl2_x    (in_ctrl2_x),
    .ctrl2_y    (in_ctrl2_y),
    .ctrl3_x    (in_ctrl3_x),
    .ctrl3_y    (in_ctrl3_y),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .point_x    (out_point_x),
    .point_y    (out_point_y),
    .last_point (out_last_point)
  );

  // a new item is only taken with no point of the previous one pending
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("item taken while points still pending");

  // nothing follows the last point of an item
  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_point |=> !out_valid)
    else $error("point after the last point of an item");

  // the last point ends issuing for the item
  a_last_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue && cmd.last |=> !cmd.issue)
    else $error("point issued after the last point");

endmodule
